// ===== sv/droptail_delay_shaper_defines.svh =====
// Assertion macros shared by the shaper's modules.
// Each macro expects i_clk and i_rst_n in the scope of the module that uses it.
`ifndef DROPTAIL_DELAY_SHAPER_DEFINES_SVH
`define DROPTAIL_DELAY_SHAPER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DTDS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DTDS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/dtds_pkg.sv =====
`default_nettype none

package dtds_pkg;

    // Field and register widths.
    localparam int TIME_W  = 48;
    localparam int BYTES_W = 16;
    localparam int BITS_W  = BYTES_W + 3;
    localparam int RATE_W  = 40;
    localparam int TICK_W  = 32;
    localparam int LAT_W   = 32;
    localparam int CFG_W   = 48;
    localparam int PROD_W  = BITS_W + TICK_W;
    localparam int TRIAL_W = PROD_W + 2;
    localparam int CNT_W   = $clog2(PROD_W + 1);

    // Register reset values.
    localparam logic [RATE_W-1:0] BITRATE_RST = RATE_W'(64'd1000000000);
    localparam logic [TICK_W-1:0] TICK_RST    = TICK_W'(64'd1000000);
    localparam logic [TIME_W-1:0] MAXDLY_RST  = TIME_W'(64'd1000);

    // Result status codes.
    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_DROP   = 2'd1,
        STS_BADLEN = 2'd2
    } t_status;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_BITRATE = 2'd0,
        REG_TICK    = 2'd1,
        REG_MAXDLY  = 2'd2,
        REG_FIXLAT  = 2'd3
    } t_reg_idx;

    // Divider status seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

// ===== sv/dtds_div.sv =====
`default_nettype none
`include "droptail_delay_shaper_defines.svh"

// Restoring radix-2 divider: one quotient bit per cycle, PROD_W quotient bits per division.
module dtds_div import dtds_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [PROD_W-1:0] i_dividend,
    input  wire logic [RATE_W-1:0] i_divisor,
    output t_div_stat              o_stat,
    output logic      [PROD_W-1:0] o_quot
);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [RATE_W:0]   r_rem;
    logic [PROD_W-1:0] r_q;
    logic [RATE_W-1:0] r_dvs;

    logic [RATE_W:0]   rem_sh;
    logic              ge;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    assign rem_sh = {r_rem[RATE_W-1:0], r_q[PROD_W-1]};
    assign ge     = (rem_sh >= {1'b0, r_dvs});

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(PROD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend register fills with quotient bits as it shifts out.
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
            r_q   <= {r_q[PROD_W-2:0], ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_q;

    `DTDS_ASSERT_NXT(a_div_start_busy, i_start && !r_busy, r_busy, "divider did not start")
    `DTDS_ASSERT_NXT(a_div_done_idle, r_done, !r_busy && !r_done, "done is not a single pulse")
    `DTDS_ASSERT_IMP(a_div_rem_bound, r_busy && (r_dvs != '0), r_rem < {1'b0, r_dvs},
        "partial remainder not below divisor")

endmodule

`default_nettype wire

// ===== sv/droptail_delay_shaper.sv =====
// A word of non-zero length steps through CALC, DIVGO, DIVW (the bit-serial divider), ADD, CHK
// and DONE, a zero length straight to DONE; no new word is taken until the current one leaves DONE.
// A new word is taken as soon as the sequencer is idle, even while a result still waits.
// Reset (synchronous, active low) clears backlog, last arrival and handshake state,
// and loads the configuration registers with their documented defaults.
`default_nettype none
`include "droptail_delay_shaper_defines.svh"

module droptail_delay_shaper import dtds_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [63:0]       s_axis_tdata,   // arrival_time[47:0], packet_bytes[63:48]
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [TIME_W-1:0]      m_axis_tdata,   // send_delay[47:0]
    output logic [1:0]             m_axis_tuser,   // status[1:0]
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [CFG_W-1:0]  i_cfg_data
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CALC  = 7'b0000010,
        ST_DIVGO = 7'b0000100,
        ST_DIVW  = 7'b0001000,
        ST_ADD   = 7'b0010000,
        ST_CHK   = 7'b0100000,
        ST_DONE  = 7'b1000000
    } t_state;

    t_state              r_state, n_state;

    // Configuration registers.
    logic [RATE_W-1:0]   r_bitrate;
    logic [TICK_W-1:0]   r_tick;
    logic [TIME_W-1:0]   r_max;
    logic [LAT_W-1:0]    r_fixed;

    // Queue state.
    logic [TIME_W-1:0]   r_backlog;
    logic [TIME_W-1:0]   r_last;

    // Working registers for the current word.
    logic [TIME_W-1:0]   r_now;
    logic [BYTES_W-1:0]  r_bytes;
    logic [PROD_W-1:0]   r_prod;
    logic [TRIAL_W-1:0]  r_trial;
    t_status             r_res_sts;
    logic [TIME_W-1:0]   r_res_delay;

    // Output register.
    logic                r_out_valid;
    t_status             r_out_sts;
    logic [TIME_W-1:0]   r_out_delay;

    logic                in_acc;
    logic                out_load;
    logic [TIME_W-1:0]   gap;
    logic [BITS_W-1:0]   bits;
    logic [RATE_W-1:0]   divisor;
    logic                drop;
    logic [TRIAL_W-1:0]  total;
    t_div_stat           div_stat;
    logic [PROD_W-1:0]   div_quot;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_load      = (r_state == ST_DONE) && (!r_out_valid || m_axis_tready);
    assign o_cfg_ready   = 1'b1;

    assign gap     = r_now - r_last;
    assign bits    = {r_bytes, 3'b000};
    assign divisor = (r_bitrate == '0) ? RATE_W'(1) : r_bitrate;
    assign drop    = (r_trial > TRIAL_W'(r_max));
    assign total   = r_trial + TRIAL_W'(r_fixed);

    // Transmission time divider.
    dtds_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == ST_DIVGO),
        .i_dividend (r_prod),
        .i_divisor  (divisor),
        .o_stat     (div_stat),
        .o_quot     (div_quot)
    );

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = (s_axis_tdata[63:48] == '0) ? ST_DONE : ST_CALC;
                end
            end
            ST_CALC:  n_state = ST_DIVGO;
            ST_DIVGO: n_state = ST_DIVW;
            ST_DIVW: begin
                if (div_stat.done) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD:   n_state = ST_CHK;
            ST_CHK:   n_state = ST_DONE;
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bitrate <= BITRATE_RST;
            r_tick    <= TICK_RST;
            r_max     <= MAXDLY_RST;
            r_fixed   <= '0;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_BITRATE: r_bitrate <= i_cfg_data[RATE_W-1:0];
                REG_TICK:    r_tick    <= i_cfg_data[TICK_W-1:0];
                REG_MAXDLY:  r_max     <= i_cfg_data[TIME_W-1:0];
                REG_FIXLAT:  r_fixed   <= i_cfg_data[LAT_W-1:0];
                default:     r_fixed   <= r_fixed;
            endcase
        end
    end

    // Backlog and last arrival: drain when time advances, then load the accepted delay.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_backlog <= '0;
            r_last    <= '0;
        end else if (r_state == ST_CALC) begin
            if (r_now > r_last) begin
                r_backlog <= (gap >= r_backlog) ? '0 : (r_backlog - gap);
                r_last    <= r_now;
            end
        end else if ((r_state == ST_CHK) && !drop) begin
            r_backlog <= (total[TRIAL_W-1:TIME_W] != '0) ? '1 : total[TIME_W-1:0];
        end
    end

    // Per-word datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_now       <= s_axis_tdata[TIME_W-1:0];
                r_bytes     <= s_axis_tdata[63:48];
                r_res_sts   <= STS_BADLEN;
                r_res_delay <= '0;
            end
            ST_CALC: begin
                r_prod <= PROD_W'(bits) * PROD_W'(r_tick);
            end
            ST_ADD: begin
                r_trial <= TRIAL_W'(r_backlog) + TRIAL_W'(div_quot) + TRIAL_W'(1);
            end
            ST_CHK: begin
                if (drop) begin
                    r_res_sts   <= STS_DROP;
                    r_res_delay <= '0;
                end else begin
                    r_res_sts   <= STS_OK;
                    r_res_delay <= (total[TRIAL_W-1:TIME_W] != '0) ? '1 : total[TIME_W-1:0];
                end
            end
            default: begin
                r_prod <= r_prod;
            end
        endcase
    end

    // Output register: holds a finished word while the next one is worked on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_sts   <= r_res_sts;
            r_out_delay <= r_res_delay;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_delay;
    assign m_axis_tuser  = r_out_sts;

    `DTDS_ASSERT_IMP(a_idle_div_free, r_state == ST_IDLE, !div_stat.busy,
        "divider busy while sequencer idle")
    `DTDS_ASSERT_IMP(a_nonok_zero, m_axis_tvalid && (m_axis_tuser != STS_OK),
        m_axis_tdata == '0, "dropped or bad word carries a delay")
    `DTDS_ASSERT_NXT(a_backlog_match, (r_state == ST_CHK) && !drop,
        r_backlog == r_res_delay, "backlog differs from reported delay")

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import dtds_pkg::*;

    localparam logic [47:0] T_MAX       = 48'hFFFF_FFFF_FFFF;
    localparam int          QUIET_LIMIT = 5000;
    localparam int          SETTLE      = 64;

    // One packet arrival as it is offered to the shaper.
    typedef struct packed {
        logic [47:0] arrival;
        logic [15:0] nbytes;
    } t_packet;

    // One shaping verdict as it comes back.
    typedef struct packed {
        t_status     sts;
        logic [47:0] delay;
    } t_verdict;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index   = '0;
    logic [47:0] i_cfg_data    = '0;

    droptail_delay_shaper u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Packets waiting to be offered, and verdicts waiting to come back.
    t_packet  pending_pkts[$];
    t_verdict shaped_q[$];

    // Shadow copy of the shaper's registers and queue state.
    logic [39:0] bitrate_r = BITRATE_RST;
    logic [31:0] tick_r    = TICK_RST;
    logic [47:0] maxdly_r  = MAXDLY_RST;
    logic [31:0] fixlat_r  = '0;
    logic [47:0] backlog_r = '0;
    logic [47:0] last_arr_r = '0;

    // Handshake events seen at the last rising edge.
    bit in_fire  = 1'b0;
    bit out_fire = 1'b0;
    bit cfg_fire = 1'b0;

    int fail_count = 0;
    int quiet_cycles = 0;
    int burst_left = 1;
    int gap_left = 0;
    int rx_mode = 0;
    int rx_left = 0;
    int stall_left = 0;
    int rx_cycle = 0;

    // Works out the verdict for one arrival and advances the shadow queue state.
    function automatic t_verdict shape_packet(input logic [47:0] now, input logic [15:0] nbytes);
        logic [47:0] gap;
        logic [63:0] rate;
        logic [63:0] tx;
        logic [63:0] trial;
        logic [63:0] total;
        t_verdict    v;
        v.sts   = STS_BADLEN;
        v.delay = '0;
        if (nbytes == 16'd0) begin
            return v;
        end
        // Drain only when time moves forward.
        if (now > last_arr_r) begin
            gap = now - last_arr_r;
            backlog_r  = (gap >= backlog_r) ? 48'd0 : backlog_r - gap;
            last_arr_r = now;
        end
        rate  = (bitrate_r == 40'd0) ? 64'd1 : {24'd0, bitrate_r};
        tx    = ({45'd0, nbytes, 3'd0} * {32'd0, tick_r}) / rate + 64'd1;
        trial = {16'd0, backlog_r} + tx;
        if (trial > {16'd0, maxdly_r}) begin
            v.sts = STS_DROP;
            return v;
        end
        total = trial + {32'd0, fixlat_r};
        if (total > {16'd0, T_MAX}) begin
            total = {16'd0, T_MAX};
        end
        backlog_r = total[47:0];
        v.sts     = STS_OK;
        v.delay   = total[47:0];
        return v;
    endfunction

    task automatic note_mismatch(input string what);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%s", what);
        end
    endtask

    // Rising edge: record handshakes, predict, check, and watch for a hang.
    always @(posedge i_clk) begin : mon_blk
        t_verdict want;
        in_fire  = s_axis_tvalid && s_axis_tready;
        out_fire = m_axis_tvalid && m_axis_tready;
        cfg_fire = i_cfg_valid && o_cfg_ready;
        if (i_rst_n) begin
            if (cfg_fire) begin
                case (i_cfg_index)
                    REG_BITRATE: bitrate_r = i_cfg_data[39:0];
                    REG_TICK:    tick_r    = i_cfg_data[31:0];
                    REG_MAXDLY:  maxdly_r  = i_cfg_data;
                    REG_FIXLAT:  fixlat_r  = i_cfg_data[31:0];
                    default: ;
                endcase
            end
            if (in_fire) begin
                shaped_q.push_back(shape_packet(s_axis_tdata[47:0], s_axis_tdata[63:48]));
            end
            if (out_fire) begin
                if (shaped_q.size() == 0) begin
                    note_mismatch($sformatf("unexpected word: status %0d send_delay %0d",
                                            m_axis_tuser, m_axis_tdata));
                end else begin
                    want = shaped_q.pop_front();
                    if (m_axis_tuser !== want.sts || m_axis_tdata !== want.delay) begin
                        note_mismatch($sformatf(
                            "mismatch: status exp %0d got %0d, send_delay exp %0d got %0d",
                            want.sts, m_axis_tuser, want.delay, m_axis_tdata));
                    end
                end
            end
            if (in_fire || out_fire || cfg_fire) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Packet driver: offers words in bursts with random gaps between them.
    always @(negedge i_clk) begin : drv_blk
        t_packet pkt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (gap_left != 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_pkts.size() != 0) begin
                pkt = pending_pkts.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {pkt.nbytes, pkt.arrival};
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 10);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: switches among always-ready, coin-flip, periodic and long-stall modes.
    always @(negedge i_clk) begin
        rx_cycle++;
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(50, 400);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 1) == 1);
            2: m_axis_tready <= ((rx_cycle % 5) < 2);
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                    if ($urandom_range(0, 19) == 0) begin
                        stall_left = $urandom_range(10, 60);
                    end
                end
            end
        endcase
    end

    task automatic add_packet(input logic [47:0] arrival, input logic [15:0] nbytes);
        t_packet pkt;
        pkt.arrival = arrival;
        pkt.nbytes  = nbytes;
        pending_pkts.push_back(pkt);
    endtask

    // Waits until every packet is taken and every verdict is back, then lets the block settle.
    task automatic wait_drained;
        while (pending_pkts.size() != 0 || shaped_q.size() != 0 || s_axis_tvalid) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [47:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        while (!cfg_fire) begin
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stim_blk
        logic [47:0] t_now;
        logic [47:0] maxd;
        logic [39:0] br;
        logic [31:0] tick;
        logic [15:0] len;
        int          shift;
        int          mean_tx;
        int          sel;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(negedge i_clk);

        // Reset settings: zero length, standing and backward time, drop, drain.
        add_packet(48'd0, 16'd0);
        add_packet(48'd100, 16'd1);
        add_packet(48'd100, 16'hFFFF);
        add_packet(48'd50, 16'hFFFF);
        add_packet(48'd50, 16'd0);
        add_packet(48'd600, 16'd1);
        add_packet(48'd2000, 16'h8000);
        add_packet(48'd1000, 16'h5555);
        add_packet(48'd5000, 16'hAAAA);
        add_packet(48'd5000, 16'h7FFF);
        wait_drained();

        // Zero bitrate and zero tick rate: every packet costs one tick.
        write_reg(REG_BITRATE, 48'd0);
        write_reg(REG_TICK, 48'd0);
        write_reg(REG_MAXDLY, 48'd3);
        write_reg(REG_FIXLAT, 48'd0);
        add_packet(48'd8000, 16'd1);
        add_packet(48'd8000, 16'hFFFF);
        add_packet(48'd8000, 16'd7);
        add_packet(48'd8000, 16'd9);
        add_packet(48'd8001, 16'd3);
        wait_drained();

        // Widest bitrate with an empty delay budget: everything valid drops.
        write_reg(REG_BITRATE, 48'h00FF_FFFF_FFFF);
        write_reg(REG_TICK, 48'd1);
        write_reg(REG_MAXDLY, 48'd0);
        add_packet(48'd9000, 16'd1);
        add_packet(48'd9500, 16'hFFFF);
        add_packet(48'd9500, 16'd0);
        wait_drained();

        // Random settings, each followed by a run of random arrivals.
        t_now = 48'd10000;
        for (int ph = 0; ph < 8; ph++) begin
            shift   = $urandom_range(0, 8);
            tick    = $urandom;
            br      = {8'd0, tick} << shift;
            mean_tx = (6000 >> shift) + 1;
            if (ph == 3) begin
                maxd = 48'({$urandom, $urandom});
                write_reg(REG_FIXLAT, {16'd0, $urandom});
            end else begin
                maxd = 48'(mean_tx * $urandom_range(1, 20));
                write_reg(REG_FIXLAT, ($urandom_range(0, 4) == 0) ? 48'd0 :
                                      48'($urandom_range(0, mean_tx)));
            end
            write_reg(REG_BITRATE, {8'd0, br});
            write_reg(REG_TICK, {16'd0, tick});
            write_reg(REG_MAXDLY, maxd);
            for (int k = 0; k < 81; k++) begin
                sel = $urandom_range(0, 99);
                if (sel < 70)      len = 16'($urandom_range(1, 1500));
                else if (sel < 80) len = 16'($urandom_range(1, 64));
                else if (sel < 85) len = 16'd0;
                else if (sel < 95) len = 16'($urandom);
                else               len = 16'hFFFF;
                sel = $urandom_range(0, 99);
                if (sel < 65) begin
                    t_now = t_now + 48'($urandom_range(0, 2 * mean_tx));
                    add_packet(t_now, len);
                end else if (sel < 80) begin
                    t_now = t_now + 48'($urandom_range(0, 40 * mean_tx));
                    add_packet(t_now, len);
                end else if (sel < 90) begin
                    add_packet(t_now, len);
                end else begin
                    add_packet(t_now - 48'($urandom_range(1, mean_tx)), len);
                end
            end
            wait_drained();
        end

        // Extreme settings last, since a top timestamp stops all later drains.
        write_reg(REG_BITRATE, 48'd1);
        write_reg(REG_TICK, 48'hFFFF_FFFF);
        write_reg(REG_MAXDLY, T_MAX);
        write_reg(REG_FIXLAT, 48'hFFFF_FFFF);
        add_packet(48'h5555_5555_5555, 16'd8192);
        add_packet(48'h5555_5555_5555, 16'd1);
        add_packet(48'hAAAA_AAAA_AAAA, 16'd8191);
        add_packet(T_MAX, 16'd8191);
        add_packet(T_MAX, 16'hFFFF);
        add_packet(T_MAX, 16'd0);
        wait_drained();

        if (fail_count == 0 && shaped_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/dtds_pkg.sv
sv/dtds_div.sv
sv/droptail_delay_shaper.sv
tb/sv/tb_top.sv
